// ===== rtl/core/nfd_pkg.sv =====
package nfd_pkg;

   // Frame parser phases
   typedef enum logic [3:0] {
      PH_SEARCH = 4'd0,
      PH_LEN    = 4'd1,
      PH_LCS    = 4'd2,
      PH_TFI    = 4'd3,
      PH_DATA   = 4'd4,
      PH_DCS    = 4'd5,
      PH_DONE   = 4'd6
   } nfd_phase_type;

   // Result kinds
   typedef enum logic [2:0] {
      K_PAYLOAD = 3'd0,
      K_OK      = 3'd1,
      K_ACK     = 3'd2,
      K_NACK    = 3'd3,
      K_EXT     = 3'd4,
      K_BADLEN  = 3'd5,
      K_BADSUM  = 3'd6,
      K_TRUNC   = 3'd7
   } nfd_kind_type;

   localparam logic [7:0]  BYTE_ZERO = 8'h00;
   localparam logic [7:0]  BYTE_ONES = 8'hFF;
   localparam logic [15:0] HIST_IDLE = 16'hFFFF;
   localparam logic [15:0] HIST_SOF  = 16'h0000;

   // One received byte as held in the input register
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } nfd_item_type;

   // One result transaction from the parser
   typedef struct packed {
      logic         valid;
      nfd_kind_type kind;
      logic [7:0]   value;
      logic [7:0]   payload_count;
      logic         frame_final;
   } nfd_result_type;

endpackage

// ===== rtl/core/nfd_in_stage.sv =====
module nfd_in_stage
   import nfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   input  logic         req_buffer_end,
   input  logic         out_ready,
   output logic         advance,
   output nfd_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   nfd_item_type item_ff;
   logic         load;

   // Held byte moves on whenever the result register can take its outcome
   assign advance   = valid_ff & out_ready;
   assign req_stall = valid_ff & ~out_ready;
   assign load      = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.rx_byte    <= req_rx_byte;
         item_ff.buffer_end <= req_buffer_end;
      end
   end

   assign item = item_ff;

endmodule

// ===== rtl/core/nfd_parse.sv =====
module nfd_parse
   import nfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  nfd_item_type   item,
   output nfd_result_type result
);

   nfd_phase_type phase_ff, phase_in;
   logic [15:0]   history_ff, history_in;
   logic [7:0]    length_ff, length_in;
   logic [7:0]    left_ff, left_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    id_ff, id_in;
   logic [7:0]    b;
   logic [7:0]    len_check;
   logic [7:0]    data_check;

   assign b          = item.rx_byte;
   assign len_check  = length_ff + b;
   assign data_check = sum_ff + b;

   // Next state and result for the byte in the input register
   always_comb begin
      phase_in   = phase_ff;
      history_in = history_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      sum_in     = sum_ff;
      id_in      = id_ff;
      result     = '0;

      case (phase_ff)
         PH_SEARCH: begin
            if (history_ff == HIST_SOF && b == BYTE_ONES) begin
               phase_in   = PH_LEN;
               history_in = HIST_IDLE;
            end else begin
               history_in = {history_ff[7:0], b};
            end
         end
         PH_LEN: begin
            length_in = b;
            phase_in  = PH_LCS;
         end
         PH_LCS: begin
            result.valid = 1'b1;
            if (length_ff == BYTE_ZERO && b == BYTE_ONES) begin
               result.kind = K_ACK;
            end else if (length_ff == BYTE_ONES && b == BYTE_ZERO) begin
               result.kind = K_NACK;
            end else if (length_ff == BYTE_ONES && b == BYTE_ONES) begin
               result.kind = K_EXT;
            end else if (length_ff == BYTE_ZERO || len_check != BYTE_ZERO) begin
               result.kind = K_BADLEN;
            end else begin
               result.valid = 1'b0;
               left_in      = length_ff - 8'd1;
               sum_in       = BYTE_ZERO;
               phase_in     = PH_TFI;
            end
            if (result.valid) begin
               phase_in = PH_DONE;
            end
         end
         PH_TFI: begin
            id_in    = b;
            sum_in   = b;
            phase_in = (left_ff == BYTE_ZERO) ? PH_DCS : PH_DATA;
         end
         PH_DATA: begin
            sum_in       = data_check;
            left_in      = left_ff - 8'd1;
            // last payload byte when the count is about to reach zero
            if (left_ff == 8'd1) begin
               phase_in = PH_DCS;
            end
            result.valid = 1'b1;
            result.kind  = K_PAYLOAD;
            result.value = b;
         end
         PH_DCS: begin
            result.valid = 1'b1;
            if (data_check == BYTE_ZERO) begin
               result.kind          = K_OK;
               result.value         = id_ff;
               result.payload_count = length_ff - 8'd1;
            end else begin
               result.kind = K_BADSUM;
            end
            phase_in = PH_DONE;
         end
         default: begin
            // done: drop bytes until the buffer ends
         end
      endcase

      // Buffer end: flag truncation if no status was given, then restart the search
      if (item.buffer_end) begin
         if (phase_in != PH_DONE) begin
            result               = '0;
            result.valid         = 1'b1;
            result.kind          = K_TRUNC;
         end
         phase_in   = PH_SEARCH;
         history_in = HIST_IDLE;
         length_in  = BYTE_ZERO;
         left_in    = BYTE_ZERO;
         sum_in     = BYTE_ZERO;
         id_in      = BYTE_ZERO;
      end

      result.frame_final = result.valid & (result.kind != K_PAYLOAD);
      if (!advance) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SEARCH;
         history_ff <= HIST_IDLE;
         length_ff  <= BYTE_ZERO;
         left_ff    <= BYTE_ZERO;
         sum_ff     <= BYTE_ZERO;
         id_ff      <= BYTE_ZERO;
      end else if (advance) begin
         phase_ff   <= phase_in;
         history_ff <= history_in;
         length_ff  <= length_in;
         left_ff    <= left_in;
         sum_ff     <= sum_in;
         id_ff      <= id_in;
      end
   end

`ifndef ASSERT_OFF
   // A consumed buffer end always returns to the start search
   assert property (@(posedge clock) disable iff (reset)
      advance && item.buffer_end |=> phase_ff == PH_SEARCH && history_ff == HIST_IDLE)
      else $error("parser did not restart after buffer end");

   // Payload bytes only come out of the data phase
   assert property (@(posedge clock) disable iff (reset)
      result.valid && result.kind == K_PAYLOAD |-> phase_ff == PH_DATA)
      else $error("payload result outside data phase");

   // A consumed byte in the done phase gives nothing unless the buffer ends there
   assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_DONE && !item.buffer_end |-> !result.valid)
      else $error("result produced after frame status");

   // The data phase never runs with no bytes left
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> left_ff != BYTE_ZERO)
      else $error("data phase with zero byte count");
`endif

endmodule

// ===== rtl/core/nfd_out_stage.sv =====
module nfd_out_stage
   import nfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  nfd_result_type result,
   output logic           out_ready,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [2:0]     rsp_kind,
   output logic [7:0]     rsp_value,
   output logic [7:0]     rsp_payload_count,
   output logic           rsp_frame_final
);

   logic         valid_ff;
   logic         valid_in;
   nfd_kind_type kind_ff;
   logic [7:0]   value_ff;
   logic [7:0]   count_ff;
   logic         final_ff;

   // Free when empty or being drained this cycle
   assign out_ready = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && result.valid) begin
         kind_ff  <= result.kind;
         value_ff <= result.value;
         count_ff <= result.payload_count;
         final_ff <= result.frame_final;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_value         = value_ff;
   assign rsp_payload_count = count_ff;
   assign rsp_frame_final   = final_ff;

endmodule

// ===== rtl/core/nfc_frame_deframer_unit.sv =====
// Byte-serial deframer for normal information frames (00 00 FF LEN LCS TFI
// data DCS). One received byte is taken per cycle, with buffer_end on the last
// byte of a receive buffer. Each byte yields at most one result transaction:
// a payload byte as it arrives, or a final status (frame ok with TFI and
// payload count, ack, nack, extended unsupported, bad length, bad checksum,
// truncated) with frame_final set. An accepted request reaches the response
// through an input register, one pass of the byte parser, and the result
// register; a byte is accepted every cycle while the response side is not
// stalled. After a status, bytes are dropped until the buffer ends, and every
// buffer end restarts the start-sequence search.
module nfc_frame_deframer_unit
   import nfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_buffer_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic [7:0] rsp_payload_count,
   output logic       rsp_frame_final
);

   logic           out_ready;
   logic           advance;
   nfd_item_type   item;
   nfd_result_type result;

   nfd_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .req_buffer_end (req_buffer_end),
      .out_ready      (out_ready),
      .advance        (advance),
      .item           (item)
   );

   nfd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   nfd_out_stage u_out_stage (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .out_ready         (out_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_value         (rsp_value),
      .rsp_payload_count (rsp_payload_count),
      .rsp_frame_final   (rsp_frame_final)
   );

endmodule

// ===== sim/nfd_frame_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the deframer, keeps its own parser state, and
// compares every response transaction against the oldest predicted one.
module nfd_frame_checker
   import nfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_buffer_end,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_kind,
   input  logic [7:0] rsp_value,
   input  logic [7:0] rsp_payload_count,
   input  logic       rsp_frame_final,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      nfd_kind_type kind;
      logic [7:0]   value;
      logic [7:0]   count;
      logic         fin;
   } deframed_type;

   deframed_type deframed_q[$];

   // Shadow parser state
   nfd_phase_type ph;
   logic [15:0]   hist;
   logic [7:0]    flen;
   logic [7:0]    left;
   logic [7:0]    rsum;
   logic [7:0]    fid;

   task automatic restart_parser();
      ph   = PH_SEARCH;
      hist = HIST_IDLE;
      flen = BYTE_ZERO;
      left = BYTE_ZERO;
      rsum = BYTE_ZERO;
      fid  = BYTE_ZERO;
   endtask

   // Advance the shadow parser by one byte; queue the response it causes
   task automatic parse_rx_byte(input logic [7:0] b, input logic last);
      logic         emit;
      logic [7:0]   lsum;
      logic [7:0]   dsum;
      deframed_type r;
      emit = 1'b0;
      r    = '{K_PAYLOAD, BYTE_ZERO, BYTE_ZERO, 1'b0};
      lsum = flen + b;
      dsum = rsum + b;
      case (ph)
         PH_SEARCH: begin
            if (hist == HIST_SOF && b == BYTE_ONES) begin
               ph   = PH_LEN;
               hist = HIST_IDLE;
            end else begin
               hist = {hist[7:0], b};
            end
         end
         PH_LEN: begin
            flen = b;
            ph   = PH_LCS;
         end
         PH_LCS: begin
            emit = 1'b1;
            if (flen == BYTE_ZERO && b == BYTE_ONES) begin
               r.kind = K_ACK;
            end else if (flen == BYTE_ONES && b == BYTE_ZERO) begin
               r.kind = K_NACK;
            end else if (flen == BYTE_ONES && b == BYTE_ONES) begin
               r.kind = K_EXT;
            end else if (flen == BYTE_ZERO || lsum != BYTE_ZERO) begin
               r.kind = K_BADLEN;
            end else begin
               emit = 1'b0;
               left = flen - 8'd1;
               rsum = BYTE_ZERO;
               ph   = PH_TFI;
            end
            if (emit) ph = PH_DONE;
         end
         PH_TFI: begin
            fid  = b;
            rsum = b;
            ph   = (left == BYTE_ZERO) ? PH_DCS : PH_DATA;
         end
         PH_DATA: begin
            rsum    = dsum;
            left    = left - 8'd1;
            if (left == BYTE_ZERO) ph = PH_DCS;
            emit    = 1'b1;
            r.value = b;
         end
         PH_DCS: begin
            emit = 1'b1;
            if (dsum == BYTE_ZERO) begin
               r.kind  = K_OK;
               r.value = fid;
               r.count = flen - 8'd1;
            end else begin
               r.kind = K_BADSUM;
            end
            ph = PH_DONE;
         end
         default: ;
      endcase
      // buffer end: report truncation if no status yet, then resync
      if (last) begin
         if (ph != PH_DONE) begin
            emit = 1'b1;
            r    = '{K_TRUNC, BYTE_ZERO, BYTE_ZERO, 1'b0};
         end
         restart_parser();
      end
      if (emit) begin
         r.fin = (r.kind != K_PAYLOAD);
         deframed_q.push_back(r);
      end
   endtask

   // Check responses first, then predict from the request accepted this edge
   always @(posedge clock) begin
      deframed_type e;
      if (reset) begin
         restart_parser();
         deframed_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (deframed_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response: kind=%0d value=%02h count=%0d final=%0b",
                           rsp_kind, rsp_value, rsp_payload_count, rsp_frame_final);
            end else begin
               e = deframed_q.pop_front();
               if (rsp_kind !== e.kind || rsp_value !== e.value ||
                   rsp_payload_count !== e.count || rsp_frame_final !== e.fin) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("response mismatch: exp kind=%0d value=%02h count=%0d final=%0b,",
                              e.kind, e.value, e.count, e.fin,
                              " got kind=%0d value=%02h count=%0d final=%0b",
                              rsp_kind, rsp_value, rsp_payload_count, rsp_frame_final);
               end
            end
         end
         if (req_valid && !req_stall)
            parse_rx_byte(req_rx_byte, req_buffer_end);
      end
      pending = deframed_q.size();
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
   import nfd_pkg::*;
();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1650;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       req_buffer_end;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_value;
   logic [7:0] rsp_payload_count;
   logic       rsp_frame_final;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int send_idle_pct;
   int recv_idle_pct;
   int random_items;
   int buffer_idx;

   logic [7:0] frame_bytes[$];

   nfc_frame_deframer_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_buffer_end    (req_buffer_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_value         (rsp_value),
      .rsp_payload_count (rsp_payload_count),
      .rsp_frame_final   (rsp_frame_final)
   );

   nfd_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_buffer_end    (req_buffer_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_value         (rsp_value),
      .rsp_payload_count (rsp_payload_count),
      .rsp_frame_final   (rsp_frame_final),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always #6 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response side back-pressure
   always @(negedge clock) begin
      if (reset)
         rsp_stall = 1'b0;
      else
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
   end

   // One request transaction, with random idle cycles ahead of it
   task push_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid      = 1'b0;
         req_rx_byte    = 8'($urandom);
         req_buffer_end = 1'($urandom);
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_rx_byte    = b;
      req_buffer_end = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Send the assembled buffer, marking its last byte
   task send_buffer();
      for (int i = 0; i < frame_bytes.size(); i++)
         push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      frame_bytes.delete();
   endtask

   task wait_drained();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task add_header();
      frame_bytes.push_back(BYTE_ZERO);
      frame_bytes.push_back(BYTE_ZERO);
      frame_bytes.push_back(BYTE_ONES);
   endtask

   // Normal information frame; optionally with a broken data checksum
   task add_info_frame(input int plen, input logic bad_dcs);
      logic [7:0] len;
      logic [7:0] sum;
      logic [7:0] d;
      len = 8'(plen + 1);
      add_header();
      frame_bytes.push_back(len);
      frame_bytes.push_back(BYTE_ZERO - len);
      sum = 8'($urandom);
      frame_bytes.push_back(sum);
      for (int i = 0; i < plen; i++) begin
         d   = 8'($urandom);
         sum = sum + d;
         frame_bytes.push_back(d);
      end
      d = BYTE_ZERO - sum;
      if (bad_dcs) d = d + 8'($urandom_range(1, 255));
      frame_bytes.push_back(d);
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(2))
         0:       return BYTE_ZERO;
         1:       return BYTE_ONES;
         default: return 8'($urandom);
      endcase
   endfunction

   // Build one random receive buffer; returns the bytes that matter
   task build_random_buffer(output int counted);
      int         sel;
      int         plen;
      int         keep;
      logic [7:0] len;
      logic [7:0] lcs;
      sel = $urandom_range(99);
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(noise_byte());
      if ($urandom_range(99) < 3)
         plen = $urandom_range(100, 254);
      else
         plen = $urandom_range(0, 12);
      if (buffer_idx == 3) plen = 254;
      if (buffer_idx == 3 || sel < 55) begin
         add_info_frame(plen, 1'b0);
      end else if (sel < 62) begin
         add_header();
         frame_bytes.push_back(BYTE_ZERO);
         frame_bytes.push_back(BYTE_ONES);
      end else if (sel < 67) begin
         add_header();
         frame_bytes.push_back(BYTE_ONES);
         frame_bytes.push_back(BYTE_ZERO);
      end else if (sel < 71) begin
         add_header();
         frame_bytes.push_back(BYTE_ONES);
         frame_bytes.push_back(BYTE_ONES);
      end else if (sel < 79) begin
         // bad length: zero length or a failed length check
         add_header();
         if ($urandom_range(3) == 0) begin
            len = BYTE_ZERO;
            lcs = 8'($urandom_range(0, 254));
         end else begin
            len = 8'($urandom);
            lcs = BYTE_ZERO - len + 8'($urandom_range(1, 255));
         end
         frame_bytes.push_back(len);
         frame_bytes.push_back(lcs);
         repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
      end else if (sel < 87) begin
         add_info_frame(plen, 1'b1);
      end else if (sel < 95) begin
         // buffer ends in the middle of a frame
         add_info_frame(plen, 1'b0);
         keep = $urandom_range(1, frame_bytes.size() - 1);
         frame_bytes = frame_bytes[0:keep-1];
      end else begin
         repeat ($urandom_range(1, 8)) frame_bytes.push_back(noise_byte());
      end
      counted = frame_bytes.size();
      // postamble and trailing bytes after a status
      if (sel < 87)
         repeat ($urandom_range(0, 2)) frame_bytes.push_back(noise_byte());
      buffer_idx++;
   endtask

   initial begin
      int counted;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_rx_byte    = BYTE_ZERO;
      req_buffer_end = 1'b0;
      send_idle_pct  = 32;
      recv_idle_pct  = 72;
      random_items   = 0;
      buffer_idx     = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: ack, nack, extended, a short good frame, early buffer end
      add_header();
      frame_bytes.push_back(BYTE_ZERO);
      frame_bytes.push_back(BYTE_ONES);
      send_buffer();
      add_header();
      frame_bytes.push_back(BYTE_ONES);
      frame_bytes.push_back(BYTE_ZERO);
      send_buffer();
      add_header();
      frame_bytes.push_back(BYTE_ONES);
      frame_bytes.push_back(BYTE_ONES);
      send_buffer();
      add_header();
      frame_bytes.push_back(8'h02);
      frame_bytes.push_back(8'hFE);
      frame_bytes.push_back(8'hD5);
      frame_bytes.push_back(8'h4B);
      frame_bytes.push_back(8'hE0);
      frame_bytes.push_back(BYTE_ZERO);
      send_buffer();
      frame_bytes.push_back(BYTE_ZERO);
      send_buffer();

      // Hold off until the parser has answered everything
      wait_drained();

      // Random buffers across three idling regimes
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= RANDOM_ITEMS * 2 / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (random_items >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 72;
            recv_idle_pct = 32;
         end
         build_random_buffer(counted);
         random_items += counted;
         send_buffer();
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== nfc_frame_deframer_unit.f =====
rtl/core/nfd_pkg.sv
rtl/core/nfd_in_stage.sv
rtl/core/nfd_parse.sv
rtl/core/nfd_out_stage.sv
rtl/core/nfc_frame_deframer_unit.sv
sim/nfd_frame_checker.sv
sim/tb_top.sv
